### rtl/core/lsws_pkg.sv
package lsws_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Field widths
    localparam int ACT_W  = 2;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;
    localparam int POS_W  = 7;

    typedef logic [ACT_W-1:0]  action_t;
    typedef logic [STAT_W-1:0] status_t;

    // Action codes
    localparam action_t ACT_PUSH    = 2'd0;
    localparam action_t ACT_POP     = 2'd1;
    localparam action_t ACT_DISPLAY = 2'd2;
    localparam action_t ACT_SEARCH  = 2'd3;

    // Status codes
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_EMPTY    = 2'd1;
    localparam status_t ST_FULL     = 2'd2;
    localparam status_t ST_NOTFOUND = 2'd3;

    // Storage access from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

### rtl/core/lsws_if.sv
interface lsws_req_if;
    logic                              valid;
    logic                              ready;
    lsws_pkg::action_t                 action;
    logic signed [lsws_pkg::WORD_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface lsws_rsp_if;
    logic                               valid;
    logic                               ready;
    lsws_pkg::status_t                  status;
    logic signed [lsws_pkg::WORD_W-1:0] word;
    logic [lsws_pkg::POS_W-1:0]         position;
    logic                               last;

    modport source (output valid, output status, output word, output position, output last,
                    input ready);
    modport sink   (input valid, input status, input word, input position, input last,
                    output ready);
endinterface

### rtl/core/lifo_stack_with_search_top.sv
// Bounded last-in-first-out stack of STACK_DEPTH signed 32-bit words with
// push, pop, display-all and search actions. Every request transaction gives
// at least one response transaction, the final one marked by last. A push
// is answered through the output register when it is taken; a pop goes
// through S_POP, as the word comes from a memory with a registered read.
// Display walks the stored words top first, one per cycle while the
// response slot is free; a search compares one stored word per cycle
// through a single comparator. The request side is not ready while a pop,
// display or search is under way. A waiting response does not block a new
// request once the earlier one has been taken in the same cycle.
module lifo_stack_with_search_top (
    input  logic        clk,
    input  logic        rst_n,
    lsws_req_if.sink    req,
    lsws_rsp_if.source  rsp
);

    lsws_pkg::ram_req_t            ram_req;
    logic [lsws_pkg::WORD_W-1:0]   ram_rdata;

    // Sequencer with shared comparator and output register
    lsws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // Stack storage
    lsws_ram #(
        .WIDTH (lsws_pkg::WORD_W),
        .DEPTH (lsws_pkg::STACK_DEPTH),
        .AW    (lsws_pkg::ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

### rtl/core/lsws_ram.sv
module lsws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/lsws_ctrl.sv
module lsws_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    lsws_req_if.sink                            req,
    lsws_rsp_if.source                          rsp,
    output lsws_pkg::ram_req_t                  ram_req,
    input  logic [lsws_pkg::WORD_W-1:0]         ram_rdata
);

    typedef enum logic [1:0] {S_IDLE, S_POP, S_DISP, S_SRCH} state_t;

    state_t                         state_reg, state_next;
    logic [lsws_pkg::CNT_W-1:0]     fill_reg, fill_next;
    logic [lsws_pkg::ADDR_W-1:0]    idx_reg, idx_next;
    logic [lsws_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [lsws_pkg::WORD_W-1:0]    key_reg, key_next;

    logic                           ovalid_reg, ovalid_next;
    lsws_pkg::status_t              ostat_reg, ostat_next;
    logic [lsws_pkg::WORD_W-1:0]    oword_reg, oword_next;
    logic [lsws_pkg::POS_W-1:0]     opos_reg, opos_next;
    logic                           olast_reg, olast_next;

    logic                           slot_free;
    logic                           hit;
    logic                           at_end;
    logic                           is_empty;
    logic                           is_full;
    logic [lsws_pkg::CNT_W-1:0]     top_full;
    logic [lsws_pkg::ADDR_W-1:0]    top_idx;
    logic                           emit;
    lsws_pkg::status_t              e_stat;
    logic [lsws_pkg::WORD_W-1:0]    e_word;
    logic [lsws_pkg::POS_W-1:0]     e_pos;
    logic                           e_last;
    logic                           we;

    // Shared compare and walk bookkeeping
    assign slot_free = !ovalid_reg || rsp.ready;
    assign hit       = (ram_rdata == key_reg);
    assign at_end    = (pos_reg == lsws_pkg::POS_W'(fill_reg));
    assign is_empty  = (fill_reg == '0);
    assign is_full   = (fill_reg == lsws_pkg::CNT_W'(lsws_pkg::STACK_DEPTH));
    assign top_full  = fill_reg - lsws_pkg::CNT_W'(1);
    assign top_idx   = top_full[lsws_pkg::ADDR_W-1:0];

    assign req.ready = (state_reg == S_IDLE) && slot_free;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        emit       = 1'b0;
        e_stat     = lsws_pkg::ST_OK;
        e_word     = '0;
        e_pos      = '0;
        e_last     = 1'b1;
        we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid && slot_free)
                begin
                    pos_next = lsws_pkg::POS_W'(1);
                    idx_next = top_idx;
                    key_next = req.value;
                    unique case (req.action)
                        lsws_pkg::ACT_PUSH:
                        begin
                            emit = 1'b1;
                            if (is_full)
                            begin
                                e_stat = lsws_pkg::ST_FULL;
                            end
                            else
                            begin
                                we        = 1'b1;
                                fill_next = fill_reg + lsws_pkg::CNT_W'(1);
                            end
                        end
                        lsws_pkg::ACT_POP:
                        begin
                            if (is_empty)
                            begin
                                emit   = 1'b1;
                                e_stat = lsws_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                fill_next  = top_full;
                                state_next = S_POP;
                            end
                        end
                        lsws_pkg::ACT_DISPLAY:
                        begin
                            if (is_empty)
                            begin
                                emit   = 1'b1;
                                e_stat = lsws_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DISP;
                            end
                        end
                        lsws_pkg::ACT_SEARCH:
                        begin
                            if (is_empty)
                            begin
                                emit   = 1'b1;
                                e_stat = lsws_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SRCH;
                            end
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    e_word     = ram_rdata;
                    state_next = S_IDLE;
                end
            end
            S_DISP:
            begin
                if (slot_free)
                begin
                    emit   = 1'b1;
                    e_word = ram_rdata;
                    e_pos  = pos_reg;
                    e_last = at_end;
                    if (at_end)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - lsws_pkg::ADDR_W'(1);
                        pos_next = pos_reg + lsws_pkg::POS_W'(1);
                    end
                end
            end
            S_SRCH:
            begin
                if (hit)
                begin
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        e_word     = key_reg;
                        e_pos      = pos_reg;
                        state_next = S_IDLE;
                    end
                end
                else if (at_end)
                begin
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        e_stat     = lsws_pkg::ST_NOTFOUND;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg - lsws_pkg::ADDR_W'(1);
                    pos_next = pos_reg + lsws_pkg::POS_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: load on emit, drop once taken
    always_comb
    begin
        ovalid_next = ovalid_reg && !rsp.ready;
        ostat_next  = ostat_reg;
        oword_next  = oword_reg;
        opos_next   = opos_reg;
        olast_next  = olast_reg;
        if (emit)
        begin
            ovalid_next = 1'b1;
            ostat_next  = e_stat;
            oword_next  = e_word;
            opos_next   = e_pos;
            olast_next  = e_last;
        end
    end

    // Storage access; the read address follows the walk index
    assign ram_req.we    = we;
    assign ram_req.waddr = fill_reg[lsws_pkg::ADDR_W-1:0];
    assign ram_req.wdata = req.value;
    assign ram_req.raddr = idx_next;

    assign rsp.valid    = ovalid_reg;
    assign rsp.status   = ostat_reg;
    assign rsp.word     = oword_reg;
    assign rsp.position = opos_reg;
    assign rsp.last     = olast_reg;

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            idx_reg    <= '0;
            pos_reg    <= '0;
            key_reg    <= '0;
            ovalid_reg <= 1'b0;
            ostat_reg  <= lsws_pkg::ST_OK;
            oword_reg  <= '0;
            opos_reg   <= '0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            idx_reg    <= idx_next;
            pos_reg    <= pos_next;
            key_reg    <= key_next;
            ovalid_reg <= ovalid_next;
            ostat_reg  <= ostat_next;
            oword_reg  <= oword_next;
            opos_reg   <= opos_next;
            olast_reg  <= olast_next;
        end
    end

endmodule
